### rtl/bcc_pkg.sv
package bcc_pkg;

    localparam int F_MAX       = 255;
    localparam int N_MAX       = 63;
    localparam int COUNT_WIDTH = 128;

    localparam int TOTAL_W = 8;
    localparam int PARTS_W = 6;
    localparam int BOUND_W = 9;

    // row index width and window counter width
    localparam int S_W       = $clog2(F_MAX + 1);
    localparam int CNT_W     = $clog2(F_MAX + 2);
    localparam int ROW_DEPTH = 2 * (F_MAX + 1);
    localparam int ENTRY_W   = COUNT_WIDTH + 1;

    typedef struct packed {
        logic clear;
        logic step;
        logic sub_en;
    } bcc_win_ctl_t;

endpackage

### rtl/bounded_composition_counter.sv
// Bounded composition counter.
// Input channel (s_valid/s_ready) carries one query: total f, parts n and
// exclusive part bound r. Result channel (m_valid/m_ready) returns the count
// of ordered compositions of f into n parts in 1..r-1, wrapped to 128 bits,
// as m_count_low/m_count_high, plus m_overflow when the exact count carried.
// One query at a time: s_ready is high only while the sequencer is idle.
// Degenerate queries (f=0, n=0, r<=1) and n=1 go from idle straight to the
// done state and the output register. Otherwise the sequencer fills row 1,
// then works one DP cell per cycle through the shared window adder for each
// further row; row stores in a two-read-port RAM with registered reads.
// A new query may be accepted while the previous result still waits; a
// finished result is held until the output register is free, so a stalled
// receiver only delays the next result. Reset (aresetn low, synchronous)
// returns to idle with no result pending; the row RAM is not cleared since
// every entry is written before it is read within a query.
module bounded_composition_counter (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bcc_pkg::TOTAL_W-1:0]  s_total,
    input  logic [bcc_pkg::PARTS_W-1:0]  s_parts,
    input  logic [bcc_pkg::BOUND_W-1:0]  s_bound,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [63:0]                  m_count_low,
    output logic [63:0]                  m_count_high,
    output logic                         m_overflow
);
    import bcc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL,
        ST_DONE
    } state_t;

    localparam int AW = $clog2(ROW_DEPTH);

    state_t                 state_reg, state_next;
    logic [S_W-1:0]         f_reg, f_next;
    logic [PARTS_W-1:0]     n_reg, n_next;
    logic [BOUND_W-1:0]     r_reg, r_next;
    logic [PARTS_W-1:0]     k_reg, k_next;
    logic                   cur_reg, cur_next;
    logic [S_W-1:0]         init_s_reg, init_s_next;
    logic [S_W-1:0]         rd_s_reg, rd_s_next;
    logic                   issue_on_reg, issue_on_next;
    logic                   pipe_valid_reg, pipe_valid_next;
    logic [S_W-1:0]         pipe_s_reg, pipe_s_next;
    logic                   pipe_sub_reg, pipe_sub_next;
    logic                   pipe_last_reg, pipe_last_next;
    logic [COUNT_WIDTH-1:0] res_count_reg, res_count_next;
    logic                   res_ovf_reg, res_ovf_next;
    logic                   m_valid_reg, m_valid_next;
    logic [COUNT_WIDTH-1:0] m_count_reg, m_count_next;
    logic                   m_ovf_reg, m_ovf_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [AW-1:0]          ram_raddr_a;
    logic [AW-1:0]          ram_raddr_b;
    logic [ENTRY_W-1:0]     ram_rdata_a;
    logic [ENTRY_W-1:0]     ram_rdata_b;

    bcc_win_ctl_t           win_ctl;
    logic [COUNT_WIDTH-1:0] win_sum;
    logic                   win_big;

    logic                   degenerate;
    logic [127:0]           count_ext;

    bcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROW_DEPTH)
    ) u_rows (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    bcc_window_unit u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (win_ctl),
        .a_val    (ram_rdata_a[COUNT_WIDTH-1:0]),
        .a_big    (ram_rdata_a[COUNT_WIDTH]),
        .b_val    (ram_rdata_b[COUNT_WIDTH-1:0]),
        .b_big    (ram_rdata_b[COUNT_WIDTH]),
        .sum_next (win_sum),
        .big_next (win_big)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign degenerate = (s_total == '0) || (s_parts == '0) || (s_bound <= BOUND_W'(1))
                        || (int'(s_total) > F_MAX) || (int'(s_parts) > N_MAX);

    always_comb begin
        state_next      = state_reg;
        f_next          = f_reg;
        n_next          = n_reg;
        r_next          = r_reg;
        k_next          = k_reg;
        cur_next        = cur_reg;
        init_s_next     = init_s_reg;
        rd_s_next       = rd_s_reg;
        issue_on_next   = issue_on_reg;
        pipe_valid_next = 1'b0;
        pipe_s_next     = pipe_s_reg;
        pipe_sub_next   = pipe_sub_reg;
        pipe_last_next  = pipe_last_reg;
        res_count_next  = res_count_reg;
        res_ovf_next    = res_ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_count_next    = m_count_reg;
        m_ovf_next      = m_ovf_reg;

        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr_a = {cur_reg, rd_s_reg - S_W'(1)};
        ram_raddr_b = {cur_reg, S_W'(BOUND_W'(rd_s_reg) - r_reg)};
        win_ctl     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    f_next      = S_W'(s_total);
                    n_next      = s_parts;
                    r_next      = s_bound;
                    k_next      = PARTS_W'(2);
                    cur_next    = 1'b0;
                    init_s_next = '0;
                    if (degenerate) begin
                        res_count_next = '0;
                        res_ovf_next   = 1'b0;
                        state_next     = ST_DONE;
                    end else if (s_parts == PARTS_W'(1)) begin
                        res_count_next = COUNT_WIDTH'(BOUND_W'(s_total) < s_bound);
                        res_ovf_next   = 1'b0;
                        state_next     = ST_DONE;
                    end else begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = {1'b0, init_s_reg};
                ram_wdata = ENTRY_W'((init_s_reg != '0) && (BOUND_W'(init_s_reg) < r_reg));
                if (init_s_reg == f_reg) begin
                    state_next = ST_ROW;
                end else begin
                    init_s_next = init_s_reg + S_W'(1);
                end
            end
            ST_ROW: begin
                win_ctl.clear = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = {~cur_reg, {S_W{1'b0}}};
                ram_wdata     = '0;
                rd_s_next     = S_W'(1);
                issue_on_next = 1'b1;
                state_next    = ST_CELL;
            end
            ST_CELL: begin
                if (issue_on_reg) begin
                    pipe_valid_next = 1'b1;
                    pipe_s_next     = rd_s_reg;
                    pipe_sub_next   = BOUND_W'(rd_s_reg) >= r_reg;
                    pipe_last_next  = (rd_s_reg == f_reg);
                    rd_s_next       = rd_s_reg + S_W'(1);
                    issue_on_next   = (rd_s_reg != f_reg);
                end
                if (pipe_valid_reg) begin
                    win_ctl.step   = 1'b1;
                    win_ctl.sub_en = pipe_sub_reg;
                    ram_we         = 1'b1;
                    ram_waddr      = {~cur_reg, pipe_s_reg};
                    ram_wdata      = {win_big, win_sum};
                    if (pipe_last_reg) begin
                        if (k_reg == n_reg) begin
                            res_count_next = win_sum;
                            res_ovf_next   = win_big;
                            state_next     = ST_DONE;
                        end else begin
                            k_next     = k_reg + PARTS_W'(1);
                            cur_next   = ~cur_reg;
                            state_next = ST_ROW;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_count_next = res_count_reg;
                    m_ovf_next   = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            issue_on_reg   <= 1'b0;
            pipe_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_on_reg   <= issue_on_next;
            pipe_valid_reg <= pipe_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        f_reg         <= f_next;
        n_reg         <= n_next;
        r_reg         <= r_next;
        k_reg         <= k_next;
        cur_reg       <= cur_next;
        init_s_reg    <= init_s_next;
        rd_s_reg      <= rd_s_next;
        pipe_s_reg    <= pipe_s_next;
        pipe_sub_reg  <= pipe_sub_next;
        pipe_last_reg <= pipe_last_next;
        res_count_reg <= res_count_next;
        res_ovf_reg   <= res_ovf_next;
        m_count_reg   <= m_count_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign count_ext    = 128'(m_count_reg);
    assign m_valid      = m_valid_reg;
    assign m_count_low  = count_ext[63:0];
    assign m_count_high = count_ext[127:64];
    assign m_overflow   = m_ovf_reg;

endmodule

### rtl/bcc_ram.sv
module bcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/bcc_window_unit.sv
module bcc_window_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bcc_pkg::bcc_win_ctl_t            ctl,
    input  logic [bcc_pkg::COUNT_WIDTH-1:0]  a_val,
    input  logic                             a_big,
    input  logic [bcc_pkg::COUNT_WIDTH-1:0]  b_val,
    input  logic                             b_big,
    output logic [bcc_pkg::COUNT_WIDTH-1:0]  sum_next,
    output logic                             big_next
);
    import bcc_pkg::*;

    logic [COUNT_WIDTH-1:0] window_reg;
    logic [CNT_W-1:0]       wraps_reg;
    logic [CNT_W-1:0]       bigs_reg;

    logic [COUNT_WIDTH-1:0] b_eff;
    logic [COUNT_WIDTH+1:0] ext;
    logic [CNT_W-1:0]       wraps_step;
    logic [CNT_W-1:0]       bigs_step;

    // window + a - b in one pass; top two bits give the wrap delta (+1, 0, -1)
    always_comb begin
        b_eff      = ctl.sub_en ? b_val : '0;
        ext        = {2'b00, window_reg} + {2'b00, a_val} - {2'b00, b_eff};
        wraps_step = wraps_reg + CNT_W'(ext[COUNT_WIDTH])
                     - CNT_W'({ext[COUNT_WIDTH+1], 1'b0});
        bigs_step  = bigs_reg + CNT_W'(a_big) - CNT_W'(ctl.sub_en & b_big);
        sum_next   = ext[COUNT_WIDTH-1:0];
        big_next   = (bigs_step != '0) || (wraps_step != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            wraps_reg  <= '0;
            bigs_reg   <= '0;
        end else if (ctl.clear) begin
            window_reg <= '0;
            wraps_reg  <= '0;
            bigs_reg   <= '0;
        end else if (ctl.step) begin
            window_reg <= sum_next;
            wraps_reg  <= wraps_step;
            bigs_reg   <= bigs_step;
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int HOLDOFF_LEN = 400;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct {
        logic [63:0] low;
        logic [63:0] high;
        logic        ovf;
    } count_beat_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [TOTAL_W-1:0] s_total;
    logic [PARTS_W-1:0] s_parts;
    logic [BOUND_W-1:0] s_bound;
    logic               m_valid;
    logic               m_ready;
    logic [63:0]        m_count_low;
    logic [63:0]        m_count_high;
    logic               m_overflow;

    // predictor state: two DP rows with their carry flags
    count_t      dp_row [2][F_MAX+1];
    logic        dp_big [2][F_MAX+1];
    count_t      run_sum;
    logic        last_carry;

    count_beat_t pending_counts[$];
    int          mismatch_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_cycles;

    bounded_composition_counter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_total      (s_total),
        .s_parts      (s_parts),
        .s_bound      (s_bound),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_count_low  (m_count_low),
        .m_count_high (m_count_high),
        .m_overflow   (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t timeout with %0d counts outstanding", $time, pending_counts.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic count_beat_t count_compositions(input int f, input int n, input int r);
        count_beat_t       res;
        logic [COUNT_WIDTH:0] wide;
        logic [127:0]      ext;
        int                cur;
        int                prv;
        int                nxt;
        int                wraps;
        int                bigs;
        int                j;
        logic              c;
        cur = 0;
        if (f < 1 || n < 1 || r <= 1 || f > F_MAX || n > N_MAX) begin
            last_carry = 1'b0;
            res.low  = '0;
            res.high = '0;
            res.ovf  = 1'b0;
            return res;
        end
        for (int s = 0; s <= f; s++) begin
            dp_row[0][s] = (s >= 1 && s < r) ? count_t'(1) : count_t'(0);
            dp_big[0][s] = 1'b0;
        end
        for (int k = 2; k <= n; k++) begin
            prv = cur;
            nxt = cur ^ 1;
            wraps = 0;
            bigs = 0;
            run_sum = '0;
            dp_row[nxt][0] = '0;
            dp_big[nxt][0] = 1'b0;
            for (int s = 1; s <= f; s++) begin
                wide = {1'b0, run_sum} + {1'b0, dp_row[prv][s-1]};
                run_sum = wide[COUNT_WIDTH-1:0];
                wraps += int'(wide[COUNT_WIDTH]);
                bigs += int'(dp_big[prv][s-1]);
                if (s >= r) begin
                    j = s - r;
                    c = run_sum < dp_row[prv][j];
                    run_sum = run_sum - dp_row[prv][j];
                    wraps -= int'(c);
                    bigs -= int'(dp_big[prv][j]);
                end
                dp_row[nxt][s] = run_sum;
                dp_big[nxt][s] = (bigs > 0) || (wraps > 0);
            end
            cur = nxt;
        end
        last_carry = dp_big[cur][f];
        ext = 128'(dp_row[cur][f]);
        res.low  = ext[63:0];
        res.high = ext[127:64];
        res.ovf  = last_carry;
        return res;
    endfunction

    // result side: check each beat, then pick next ready
    initial begin
        count_beat_t want;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_counts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected beat: expected none, actual %h_%h ovf %b",
                             $time, m_count_high, m_count_low, m_overflow);
                end else begin
                    want = pending_counts.pop_front();
                    if (m_count_low !== want.low) begin
                        mismatch_count++;
                        $display("%0t count_low: expected %h, actual %h",
                                 $time, want.low, m_count_low);
                    end
                    if (m_count_high !== want.high) begin
                        mismatch_count++;
                        $display("%0t count_high: expected %h, actual %h",
                                 $time, want.high, m_count_high);
                    end
                    if (m_overflow !== want.ovf) begin
                        mismatch_count++;
                        $display("%0t overflow: expected %b, actual %b",
                                 $time, want.ovf, m_overflow);
                    end
                end
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_query(input int f, input int n, input int r);
        int gap;
        logic [TOTAL_W-1:0] tf;
        logic [PARTS_W-1:0] tn;
        logic [BOUND_W-1:0] tr;
        count_beat_t expected_beat;
        gap = 0;
        tf = TOTAL_W'(f);
        tn = PARTS_W'(n);
        tr = BOUND_W'(r);
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_total <= tf;
        s_parts <= tn;
        s_bound <= tr;
        do @(posedge aclk); while (!s_ready);
        expected_beat = count_compositions(int'(tf), int'(tn), int'(tr));
        pending_counts = {pending_counts, expected_beat};
    endtask

    task automatic wait_all_counts();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic test_degenerate();
        send_query(0, 5, 10);
        send_query(7, 0, 10);
        send_query(7, 3, 0);
        send_query(7, 3, 1);
        send_query(0, 0, 0);
        send_query(255, 63, 1);
    endtask

    task automatic test_single_part();
        send_query(5, 1, 6);
        send_query(5, 1, 5);
        send_query(255, 1, 256);
        send_query(255, 1, 255);
    endtask

    task automatic test_bound_beyond_total();
        send_query(10, 3, 511);
        send_query(10, 3, 11);
        send_query(10, 3, 10);
        send_query(10, 3, 300);
    endtask

    task automatic test_extremes();
        send_query(255, 63, 511);
        send_query(63, 63, 2);
        send_query(255, 2, 256);
        send_query(128, 32, 256);
        send_query(1, 1, 2);
        send_query(2, 2, 2);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int items);
        int f;
        int n;
        int r;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(9))
                6: begin
                    f = $urandom_range(255);
                    n = $urandom_range(1, 4);
                end
                7: begin
                    f = $urandom_range(24);
                    n = $urandom_range(63);
                end
                8: begin
                    f = $urandom_range(255);
                    n = $urandom_range(63);
                end
                9: begin
                    f = $urandom_range(30);
                    n = $urandom_range(8);
                end
                default: begin
                    f = $urandom_range(1, 30);
                    n = $urandom_range(1, 8);
                end
            endcase
            if ($urandom_range(3) == 0) r = $urandom_range(511);
            else r = $urandom_range(2, f + 2);
            if ($urandom_range(9) == 9) r = $urandom_range(1);
            send_query(f, n, r);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_hold_cycles = HOLDOFF_LEN;
        for (int i = 0; i < 6; i++) send_query($urandom_range(1, 20), $urandom_range(1, 6),
                                                $urandom_range(2, 22));
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_total = '0;
        s_parts = '0;
        s_bound = '0;
        mismatch_count = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cycles = 0;
        for (int b = 0; b < 2; b++) begin
            for (int s = 0; s <= F_MAX; s++) begin
                dp_row[b][s] = '0;
                dp_big[b][s] = 1'b0;
            end
        end
        run_sum = '0;
        last_carry = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_degenerate();
        test_single_part();
        test_bound_beyond_total();
        test_extremes();
        wait_all_counts();
        test_backpressure();
        test_random_traffic(36, 84, 26);
        wait_all_counts();
        test_random_traffic(84, 36, 25);
        test_random_traffic(0, 0, 25);
        wait_all_counts();
        repeat (50) @(posedge aclk);

        if (mismatch_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
